@@ sv/assert_macros.svh @@
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// antecedent implies consequent on the following edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/lrpg_pkg.sv @@
// package for the line raster point generator: widths, codes and payload types
`timescale 1ns / 1ps
`default_nettype none

package lrpg_pkg;

   localparam int COORD_BITS = 10;
   localparam int COLOR_BITS = 24;
   localparam int ERROR_BITS = COORD_BITS + 3;

   localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      logic      cmd;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic      point_valid;
      coord_type pixel_x;
      coord_type pixel_y;
      color_type color;
      logic      last_point;
   } rsp_type;

   typedef struct packed {
      logic      emit;
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_point;
      logic      busy;
   } walk_status_type;

endpackage

`default_nettype wire

@@ sv/lrpg_walk.sv @@
// line walk state machine: endpoint load, per-item point and error update
`timescale 1ns / 1ps
`default_nettype none

module lrpg_walk
   import lrpg_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            item_accept,
   input  wire req_type         item,
   output walk_status_type      status
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_VERT,
      PH_MAIN,
      PH_REPEAT
   } phase_type;

   typedef logic signed [ERROR_BITS-1:0] error_type;

   phase_type phase_ff, phase_in;
   coord_type cur_x_ff, cur_x_in;
   coord_type cur_y_ff, cur_y_in;
   coord_type stop_x_ff, stop_x_in;
   coord_type stop_y_ff, stop_y_in;
   coord_type abs_dx_ff, abs_dx_in;
   coord_type abs_dy_ff, abs_dy_in;
   logic      step_x_neg_ff, step_x_neg_in;
   logic      step_y_neg_ff, step_y_neg_in;
   error_type error_acc_ff, error_acc_in;

   coord_type x_moved;
   coord_type y_moved;
   error_type dx_ext;
   error_type error_add;
   error_type error_sub;
   logic      column_end;
   logic      last;

   function automatic coord_type coord_move(input coord_type v, input logic neg);
      coord_move = neg ? v - coord_type'(1) : v + coord_type'(1);
   endfunction

   assign x_moved    = coord_move(cur_x_ff, step_x_neg_ff);
   assign y_moved    = coord_move(cur_y_ff, step_y_neg_ff);
   assign column_end = (x_moved == stop_x_ff);
   assign dx_ext     = error_type'({3'b000, abs_dx_ff});
   assign error_add  = error_acc_ff + error_type'({2'b00, abs_dy_ff, 1'b0});
   assign error_sub  = error_acc_ff - error_type'({2'b00, abs_dx_ff, 1'b0});

   always_comb begin
      phase_in      = phase_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      stop_x_in     = stop_x_ff;
      stop_y_in     = stop_y_ff;
      abs_dx_in     = abs_dx_ff;
      abs_dy_in     = abs_dy_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_acc_in  = error_acc_ff;
      last          = 1'b0;
      if (item.cmd == CMD_LOAD) begin
         cur_x_in      = item.start_x;
         cur_y_in      = item.start_y;
         stop_x_in     = item.end_x;
         stop_y_in     = item.end_y;
         step_x_neg_in = item.end_x < item.start_x;
         step_y_neg_in = item.end_y < item.start_y;
         abs_dx_in     = step_x_neg_in ? item.start_x - item.end_x
                                       : item.end_x - item.start_x;
         abs_dy_in     = step_y_neg_in ? item.start_y - item.end_y
                                       : item.end_y - item.start_y;
         error_acc_in  = '0;
         priority if (abs_dx_in != '0) begin
            phase_in = PH_MAIN;
         end else if (abs_dy_in != '0) begin
            phase_in = PH_VERT;
         end else begin
            phase_in = PH_IDLE;
         end
      end else begin
         unique case (phase_ff)
            PH_VERT: begin
               cur_y_in = y_moved;
               if (y_moved == stop_y_ff) begin
                  phase_in = PH_IDLE;
                  last     = 1'b1;
               end
            end
            PH_MAIN: begin
               error_acc_in = error_add;
               if (error_add >= dx_ext) begin
                  phase_in = PH_REPEAT;
               end else begin
                  cur_x_in = x_moved;
                  phase_in = column_end ? PH_IDLE : PH_MAIN;
                  last     = column_end;
               end
            end
            PH_REPEAT: begin
               cur_y_in     = y_moved;
               error_acc_in = error_sub;
               if (error_sub < dx_ext) begin
                  cur_x_in = x_moved;
                  phase_in = column_end ? PH_IDLE : PH_MAIN;
                  last     = column_end;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      status.emit       = (item.cmd == CMD_STEP) && (phase_ff != PH_IDLE);
      status.pixel_x    = cur_x_ff;
      status.pixel_y    = cur_y_ff;
      status.last_point = last;
      status.busy       = (phase_ff != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         stop_x_ff     <= '0;
         stop_y_ff     <= '0;
         abs_dx_ff     <= '0;
         abs_dy_ff     <= '0;
         step_x_neg_ff <= 1'b0;
         step_y_neg_ff <= 1'b0;
         error_acc_ff  <= '0;
      end else if (item_accept) begin
         phase_ff      <= phase_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         stop_x_ff     <= stop_x_in;
         stop_y_ff     <= stop_y_in;
         abs_dx_ff     <= abs_dx_in;
         abs_dy_ff     <= abs_dy_in;
         step_x_neg_ff <= step_x_neg_in;
         step_y_neg_ff <= step_y_neg_in;
         error_acc_ff  <= error_acc_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/line_raster_point_generator.sv @@
// line raster point generator top level: handshake, brush colour and result register
// a step item that yields a point has it registered and shown on rsp_ in the cycle after it is accepted
// throughput: one item per cycle unless a waiting result is not taken, set by the single walk state update per edge
// a waiting result does not block a new item as long as it is taken in the same cycle
// reset (synchronous, active high): walk idle, no result pending, colour all ones
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module line_raster_point_generator
   import lrpg_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req_data,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_data,
   input  wire logic      csr_write_enable,
   input  wire color_type csr_write_data
);

   walk_status_type walk_status;
   logic            accept;
   logic            load_accept;
   logic            final_accept;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff;
   color_type       color_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lrpg_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .item        (req_data),
      .status      (walk_status)
   );

   assign rsp_valid_in = accept ? walk_status.emit : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         color_ff     <= COLOR_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            color_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && walk_status.emit) begin
         rsp_data_ff.point_valid <= 1'b1;
         rsp_data_ff.pixel_x     <= walk_status.pixel_x;
         rsp_data_ff.pixel_y     <= walk_status.pixel_y;
         rsp_data_ff.color       <= color_ff;
         rsp_data_ff.last_point  <= walk_status.last_point;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign load_accept  = accept && (req_data.cmd == CMD_LOAD);
   assign final_accept = accept && walk_status.emit && walk_status.last_point;

   // a load never leaves a result behind
   `ASSERT_NEXT(load_gives_no_item, clock, reset, load_accept, !rsp_valid_ff)
   // a step on an idle walk gives nothing
   `ASSERT_NEXT(idle_step_silent, clock, reset, accept && !walk_status.busy, !rsp_valid_ff)
   // the final point leaves the walk idle
   `ASSERT_NEXT(last_ends_walk, clock, reset, final_accept, !walk_status.busy)
   // an emitted step point is always flagged as a point
   `ASSERT_ALWAYS(point_flag_set, clock, reset, !rsp_valid_ff || rsp_data_ff.point_valid)

endmodule

`default_nettype wire

@@ dv/line_raster_point_generator_checker.sv @@
// checker for the line raster point generator: predicts each point and compares the rsp items
`timescale 1ns / 1ps

module line_raster_point_generator_checker
   import lrpg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_ready,
   input  req_type   req_data,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  rsp_type   rsp_data,
   input  logic      csr_write_enable,
   input  color_type csr_write_data,
   output int        fail_count,
   output int        pending_count
);

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_VERT,
      WALK_MAIN,
      WALK_REPEAT
   } walk_phase_type;

   typedef logic signed [ERROR_BITS-1:0] error_type;

   walk_phase_type walk_phase;
   coord_type      cur_x, cur_y, stop_x, stop_y;
   coord_type      abs_dx, abs_dy;
   logic           x_neg, y_neg;
   error_type      error_acc;
   color_type      brush;
   rsp_type        expected_points[$];
   int             failures = 0;

   function automatic coord_type step_coord(input coord_type value, input logic neg);
      return neg ? value - 1'b1 : value + 1'b1;
   endfunction

   function automatic error_type widen(input coord_type value);
      return $signed({{(ERROR_BITS - COORD_BITS){1'b0}}, value});
   endfunction

   task automatic next_column(output logic last);
      cur_x = step_coord(cur_x, x_neg);
      last = (cur_x == stop_x);
      walk_phase = last ? WALK_IDLE : WALK_MAIN;
   endtask

   task automatic predict_point(input req_type item, output logic has_point,
                                output rsp_type point);
      logic last;
      has_point = 1'b0;
      point = '0;
      last = 1'b0;
      if (item.cmd == CMD_LOAD) begin
         cur_x = item.start_x;
         cur_y = item.start_y;
         stop_x = item.end_x;
         stop_y = item.end_y;
         x_neg = item.end_x < item.start_x;
         y_neg = item.end_y < item.start_y;
         abs_dx = x_neg ? item.start_x - item.end_x : item.end_x - item.start_x;
         abs_dy = y_neg ? item.start_y - item.end_y : item.end_y - item.start_y;
         error_acc = '0;
         if (abs_dx != 0) begin
            walk_phase = WALK_MAIN;
         end else if (abs_dy != 0) begin
            walk_phase = WALK_VERT;
         end else begin
            walk_phase = WALK_IDLE;
         end
      end else if (walk_phase != WALK_IDLE) begin
         point.point_valid = 1'b1;
         point.pixel_x = cur_x;
         point.pixel_y = cur_y;
         point.color = brush;
         case (walk_phase)
            WALK_VERT: begin
               cur_y = step_coord(cur_y, y_neg);
               if (cur_y == stop_y) begin
                  walk_phase = WALK_IDLE;
                  last = 1'b1;
               end
            end
            WALK_MAIN: begin
               error_acc = error_acc + widen(abs_dy) + widen(abs_dy);
               if (error_acc >= widen(abs_dx)) begin
                  walk_phase = WALK_REPEAT;
               end else begin
                  next_column(last);
               end
            end
            default: begin
               cur_y = step_coord(cur_y, y_neg);
               error_acc = error_acc - widen(abs_dx) - widen(abs_dx);
               if (error_acc < widen(abs_dx)) begin
                  next_column(last);
               end
            end
         endcase
         point.last_point = last;
         has_point = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      rsp_type expected;
      rsp_type predicted;
      logic    has_point;
      if (reset) begin
         walk_phase = WALK_IDLE;
         cur_x = '0;
         cur_y = '0;
         stop_x = '0;
         stop_y = '0;
         abs_dx = '0;
         abs_dy = '0;
         x_neg = 1'b0;
         y_neg = 1'b0;
         error_acc = '0;
         brush = COLOR_RESET;
         expected_points.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("rsp item with no point expected: x %0d y %0d",
                      rsp_data.pixel_x, rsp_data.pixel_y);
               failures++;
            end else begin
               expected = expected_points.pop_front();
               if (rsp_data.point_valid !== expected.point_valid) begin
                  $error("point_valid expected %0d actual %0d",
                         expected.point_valid, rsp_data.point_valid);
                  failures++;
               end
               if (rsp_data.pixel_x !== expected.pixel_x) begin
                  $error("pixel_x expected %0d actual %0d", expected.pixel_x, rsp_data.pixel_x);
                  failures++;
               end
               if (rsp_data.pixel_y !== expected.pixel_y) begin
                  $error("pixel_y expected %0d actual %0d", expected.pixel_y, rsp_data.pixel_y);
                  failures++;
               end
               if (rsp_data.color !== expected.color) begin
                  $error("color expected %06h actual %06h", expected.color, rsp_data.color);
                  failures++;
               end
               if (rsp_data.last_point !== expected.last_point) begin
                  $error("last_point expected %0d actual %0d",
                         expected.last_point, rsp_data.last_point);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_point(req_data, has_point, predicted);
            if (has_point) begin
               expected_points.push_back(predicted);
            end
         end
         if (csr_write_enable) begin
            brush = csr_write_data;
         end
      end
      fail_count <= failures;
      pending_count <= expected_points.size();
   end

endmodule

@@ dv/line_raster_point_generator_tb.sv @@
// testbench top for the line raster point generator: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module line_raster_point_generator_tb;
   import lrpg_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 215;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;

   logic      clock;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   req_type   req_data = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   rsp_type   rsp_data;
   logic      csr_write_enable = 1'b0;
   color_type csr_write_data = '0;
   int        fail_count;
   int        pending_count;
   int        items_sent = 0;
   int        stall_cycles = 0;
   bit        quiet = 1'b0;
   bit        line_gaps = 1'b1;

   line_raster_point_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   line_raster_point_generator_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_coord();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return COORD_MAX;
         default: return $urandom_range(0, COORD_MAX);
      endcase
   endfunction

   function automatic int near_coord(input int centre);
      int value;
      value = centre + $urandom_range(0, 24) - 12;
      if (value < 0) begin
         value = 0;
      end else if (value > COORD_MAX) begin
         value = COORD_MAX;
      end
      return value;
   endfunction

   task automatic send_item(input req_type item);
      if (line_gaps && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic load_line(input int sx, input int sy, input int ex, input int ey);
      req_type item;
      item.cmd = CMD_LOAD;
      item.start_x = coord_type'(sx);
      item.start_y = coord_type'(sy);
      item.end_x = coord_type'(ex);
      item.end_y = coord_type'(ey);
      send_item(item);
   endtask

   task automatic send_steps(input int count);
      req_type item;
      repeat (count) begin
         item.cmd = CMD_STEP;
         item.start_x = coord_type'($urandom);
         item.start_y = coord_type'($urandom);
         item.end_x = coord_type'($urandom);
         item.end_y = coord_type'($urandom);
         send_item(item);
      end
   endtask

   // waits until the checker expects no more points, then idles for as many spare cycles as extra asks
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_colour(input color_type value);
      settle(4);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_lines(input int budget);
      int first;
      int sx, sy, ex, ey;
      int span, steps;
      first = items_sent;
      while (items_sent - first < budget) begin
         sx = pick_coord();
         sy = pick_coord();
         if ($urandom_range(0, 19) == 0) begin
            ex = pick_coord();
            ey = pick_coord();
         end else begin
            ex = near_coord(sx);
            ey = near_coord(sy);
         end
         case ($urandom_range(0, 29))
            0: begin
               ex = sx;
               ey = sy;
            end
            1, 2, 3: ey = sy;
            4, 5, 6: ex = sx;
            default: ;
         endcase
         span = (ex > sx ? ex - sx : sx - ex) + (ey > sy ? ey - sy : sy - ey);
         case ($urandom_range(0, 9))
            0, 1: steps = span + $urandom_range(1, 3);
            2: steps = $urandom_range(0, span);
            default: steps = span;
         endcase
         if (steps > 60) begin
            steps = $urandom_range(20, 60);
         end
         line_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 19) == 0) begin
            send_steps($urandom_range(1, 3));
         end
         load_line(sx, sy, ex, ey);
         send_steps(steps);
      end
   endtask

   initial begin
      int run;
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 200) : $urandom_range(1, 16);
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // step while idle, then a line whose start equals its end
      send_steps(1);
      load_line(5, 5, 5, 5);
      send_steps(1);
      // horizontal, then vertical with y falling at the top corner
      load_line(0, 0, 3, 0);
      send_steps(3);
      load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 3);
      send_steps(3);
      // steep with x falling, so points repeat while y moves
      load_line(2, 0, 0, 5);
      send_steps(5);
      // full-range diagonals, each abandoned by the next load
      load_line(0, 0, COORD_MAX, COORD_MAX);
      send_steps(2);
      load_line(COORD_MAX, 0, 0, COORD_MAX);
      send_steps(2);

      write_colour('0);
      random_lines(PHASE_ITEMS);
      write_colour(COLOR_RESET);
      random_lines(PHASE_ITEMS);
      repeat (3) begin
         write_colour(color_type'($urandom));
         random_lines(PHASE_ITEMS);
      end
      write_colour(color_type'($urandom));
      quiet = 1'b1;
      random_lines(PHASE_ITEMS);

      settle(DRAIN_CYCLES);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
